### rtl/core/gcsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcsa_pkg
// Shared constants and types for the glyph cache with shelf-packed atlas.
// ----------------------------------------------------------------------------
package gcsa_pkg;

	localparam int ATLAS_DIM   = 2048;
	localparam int CACHE_SLOTS = 4096;

	localparam int IDX_W   = $clog2(CACHE_SLOTS);
	localparam int EPOCH_W = 8;
	// shelf column / row reach ATLAS_DIM itself, height stays below it
	localparam int SHELF_W = $clog2(ATLAS_DIM) + 1;
	localparam int HGT_W   = $clog2(ATLAS_DIM);
	localparam int SUM_W   = ((SHELF_W > 12) ? SHELF_W : 12) + 2;

	localparam int TAG_W = 44;

	localparam logic [31:0] HASH_CP   = 32'd31;
	localparam logic [31:0] HASH_FACE = 32'd7919;
	localparam logic [31:0] HASH_SIZE = 32'd131;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_LOOK  = 3'b010,
		ST_SWEEP = 3'b100
	} state_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic               vld;
		logic [TAG_W-1:0]   tag;
		logic               present;
		logic [10:0]        x;
		logic [10:0]        y;
		logic [10:0]        w;
		logic [10:0]        h;
		logic [11:0]        off_x;
		logic [11:0]        off_y;
	} slot_t;

endpackage : gcsa_pkg
`default_nettype wire

### rtl/core/glyph_cache_shelf_atlas_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_cache_shelf_atlas_core
// Direct-mapped glyph cache with a shelf-packed atlas, slot table in one RAM.
// ----------------------------------------------------------------------------
// Pipeline: at the accept edge the slot RAM is read into rd_s1 along with the input
//   registers, then compare/place/write-back go into the output register once it is free.
// Input: in_stall is high while a word is in lookup, for the read-modify-write on the
//   slot RAM; the output register lets the next word enter while a result waits.
// Reset: shelf state and epoch clear at once, then a sweep of all CACHE_SLOTS entries with
//   in_stall high invalidates the RAM; each epoch wrap (2^EPOCH_W clears) repeats it.
module glyph_cache_shelf_atlas_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               cmd,
	input  wire logic [20:0]        codepoint,
	input  wire logic [7:0]         face,
	input  wire logic [14:0]        glyph_size,
	input  wire logic               raster_ok,
	input  wire logic [11:0]        bitmap_width,
	input  wire logic [11:0]        bitmap_height,
	input  wire logic signed [11:0] bearing_x,
	input  wire logic signed [11:0] bearing_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    hit,
	output logic                    present,
	output logic [10:0]             atlas_x,
	output logic [10:0]             atlas_y,
	output logic [10:0]             glyph_width,
	output logic [10:0]             glyph_height,
	output logic signed [11:0]      offset_x,
	output logic signed [11:0]      offset_y,
	output logic                    atlas_cleared
);
	import gcsa_pkg::*;

	localparam logic [SUM_W-1:0] DIM_E = SUM_W'(ATLAS_DIM);
	localparam logic [SUM_W-1:0] ONE_E = SUM_W'(1);

	state_t state_q;

	slot_t mem [CACHE_SLOTS];
	slot_t rd_s1;

	logic               cmd_s1;
	logic [20:0]        cp_s1;
	logic [7:0]         face_s1;
	logic [14:0]        gsize_s1;
	logic               ok_s1;
	logic [11:0]        w_s1;
	logic [11:0]        h_s1;
	logic [11:0]        bx_s1;
	logic [11:0]        by_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [EPOCH_W-1:0] epoch_q;
	logic [SHELF_W-1:0] shelf_col_q;
	logic [SHELF_W-1:0] shelf_row_q;
	logic [HGT_W-1:0]   shelf_hgt_q;
	logic [IDX_W-1:0]   sweep_addr_q;
	logic [IDX_W-1:0]   protect_idx_q;
	logic               protect_en_q;

	logic               out_valid_q;
	logic               hit_q;
	logic               present_q;
	logic [10:0]        x_q;
	logic [10:0]        y_q;
	logic [10:0]        w_q;
	logic [10:0]        h_q;
	logic signed [11:0] off_x_q;
	logic signed [11:0] off_y_q;
	logic               cleared_q;

	logic               in_acc;
	logic [31:0]        hash;
	logic [IDX_W-1:0]   idx;
	logic               adv;

	// lookup-stage results
	logic               r_hit;
	logic               r_cleared;
	logic               r_we;
	logic               r_epoch_inc;
	logic               r_shelf_ld;
	logic [SHELF_W-1:0] r_col;
	logic [SHELF_W-1:0] r_row;
	logic [HGT_W-1:0]   r_hgt;
	slot_t              r_slot;
	slot_t              r_out;

	logic [SUM_W-1:0]   w_e;
	logic [SUM_W-1:0]   h_e;
	logic [SUM_W-1:0]   col_e;
	logic [SUM_W-1:0]   row_e;
	logic [SUM_W-1:0]   hgt_e;
	logic [SUM_W-1:0]   col1;
	logic [SUM_W-1:0]   row1;
	logic [SUM_W-1:0]   hgt1;
	logic               ovf;
	logic               wide;
	logic               fit1;
	logic               fit2;
	logic               empty;
	logic               slot_live;
	logic [TAG_W-1:0]   tag_s1;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	slot_t              mem_wdata;
	logic               sweep_last;
	logic               epoch_wrap;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign hash = 32'(codepoint) * HASH_CP + 32'(face) * HASH_FACE
		+ 32'(glyph_size) * HASH_SIZE;
	assign idx  = hash[IDX_W-1:0];

	assign adv        = (state_q == ST_LOOK) && (!out_valid_q || !out_stall);
	assign sweep_last = (sweep_addr_q == {IDX_W{1'b1}});
	assign epoch_wrap = (epoch_q == {EPOCH_W{1'b1}});

	// --- lookup, placement and write-back data ---
	always_comb begin
		tag_s1    = {gsize_s1, face_s1, cp_s1};
		slot_live = rd_s1.vld && (rd_s1.epoch == epoch_q);

		w_e   = SUM_W'(w_s1);
		h_e   = SUM_W'(h_s1);
		col_e = SUM_W'(shelf_col_q);
		row_e = SUM_W'(shelf_row_q);
		hgt_e = SUM_W'(shelf_hgt_q);

		// first attempt on the current shelf, opening a new shelf on overflow
		ovf  = (col_e + w_e + ONE_E) > DIM_E;
		col1 = ovf ? '0 : col_e;
		row1 = ovf ? (row_e + hgt_e + ONE_E) : row_e;
		hgt1 = ovf ? '0 : hgt_e;
		wide = (w_e + ONE_E) > DIM_E;
		fit1 = !((row1 + h_e + ONE_E) > DIM_E) && !wide;
		// retry on an empty atlas lands at the origin
		fit2 = !wide && !((h_e + ONE_E) > DIM_E);
		empty = !ok_s1 || (w_s1 == '0) || (h_s1 == '0);

		r_hit       = 1'b0;
		r_cleared   = 1'b0;
		r_we        = 1'b0;
		r_epoch_inc = 1'b0;
		r_shelf_ld  = 1'b0;
		r_col       = shelf_col_q;
		r_row       = shelf_row_q;
		r_hgt       = shelf_hgt_q;
		r_slot      = '0;
		r_slot.vld  = 1'b1;
		r_slot.tag  = tag_s1;
		r_slot.epoch = epoch_q;
		r_out       = '0;

		priority if (cmd_s1 == CMD_CLEAR) begin
			r_cleared   = 1'b1;
			r_epoch_inc = 1'b1;
			r_shelf_ld  = 1'b1;
			r_col       = '0;
			r_row       = '0;
			r_hgt       = '0;
		end else if (slot_live && (rd_s1.tag == tag_s1)) begin
			r_hit = 1'b1;
			r_out = rd_s1;
		end else if (empty) begin
			r_we = 1'b1;
		end else if (fit1) begin
			r_we           = 1'b1;
			r_shelf_ld     = 1'b1;
			r_slot.present = 1'b1;
			r_slot.x       = col1[10:0];
			r_slot.y       = row1[10:0];
			r_slot.w       = w_s1[10:0];
			r_slot.h       = h_s1[10:0];
			r_slot.off_x   = bx_s1;
			r_slot.off_y   = by_s1;
			r_col          = SHELF_W'(col1 + w_e + ONE_E);
			r_row          = SHELF_W'(row1);
			r_hgt          = (h_e > hgt1) ? HGT_W'(h_e) : HGT_W'(hgt1);
			r_out          = r_slot;
		end else if (fit2) begin
			r_we           = 1'b1;
			r_cleared      = 1'b1;
			r_epoch_inc    = 1'b1;
			r_shelf_ld     = 1'b1;
			r_slot.epoch   = epoch_q + 1'b1;
			r_slot.present = 1'b1;
			r_slot.w       = w_s1[10:0];
			r_slot.h       = h_s1[10:0];
			r_slot.off_x   = bx_s1;
			r_slot.off_y   = by_s1;
			r_col          = SHELF_W'(w_e + ONE_E);
			r_row          = '0;
			r_hgt          = HGT_W'(h_e);
			r_out          = r_slot;
		end else begin
			// retry failed: atlas emptied, slot left invalid
			r_cleared   = 1'b1;
			r_epoch_inc = 1'b1;
			r_shelf_ld  = 1'b1;
			r_col       = '0;
			r_row       = '0;
			r_hgt       = '0;
		end
	end

	// --- RAM write port: sweep or write-back ---
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = r_slot;
		if (state_q == ST_SWEEP) begin
			mem_waddr = sweep_addr_q;
			mem_wdata = '0;
			mem_we    = !(protect_en_q && (sweep_addr_q == protect_idx_q));
		end else if (adv) begin
			mem_we = r_we;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1 <= mem[idx];
		end
	end

	// --- input stage ---
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= cmd;
			cp_s1    <= codepoint;
			face_s1  <= face;
			gsize_s1 <= glyph_size;
			ok_s1    <= raster_ok;
			w_s1     <= bitmap_width;
			h_s1     <= bitmap_height;
			bx_s1    <= bearing_x;
			by_s1    <= bearing_y;
			idx_s1   <= idx;
		end
	end

	// --- control ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			sweep_addr_q  <= '0;
			protect_idx_q <= '0;
			protect_en_q  <= 1'b0;
			epoch_q       <= '0;
			shelf_col_q   <= '0;
			shelf_row_q   <= '0;
			shelf_hgt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (adv) begin
						if (r_epoch_inc) begin
							epoch_q <= epoch_q + 1'b1;
						end
						if (r_shelf_ld) begin
							shelf_col_q <= r_col;
							shelf_row_q <= r_row;
							shelf_hgt_q <= r_hgt;
						end
						// epoch wrap: stale marks could alias, so sweep them out
						if (r_epoch_inc && epoch_wrap) begin
							state_q       <= ST_SWEEP;
							sweep_addr_q  <= '0;
							protect_idx_q <= idx_s1;
							protect_en_q  <= r_we;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// --- output register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q     <= r_hit;
			present_q <= r_out.present;
			x_q       <= r_out.x;
			y_q       <= r_out.y;
			w_q       <= r_out.w;
			h_q       <= r_out.h;
			off_x_q   <= r_out.off_x;
			off_y_q   <= r_out.off_y;
			cleared_q <= r_cleared;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign present       = present_q;
	assign atlas_x       = x_q;
	assign atlas_y       = y_q;
	assign glyph_width   = w_q;
	assign glyph_height  = h_q;
	assign offset_x      = off_x_q;
	assign offset_y      = off_y_q;
	assign atlas_cleared = cleared_q;

	// --- assertions ---
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_LOOK))
		else $error("accepted word did not enter lookup");

	a_result_from_look: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_LOOK))
		else $error("result appeared without a lookup");

	a_sweep_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) && $past(state_q == ST_SWEEP) && $past(arst_n)
		|-> (sweep_addr_q == IDX_W'($past(sweep_addr_q) + 1'b1)))
		else $error("sweep address skipped");

	a_shelf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_W'(shelf_col_q) <= DIM_E) && (SUM_W'(shelf_row_q) <= DIM_E))
		else $error("shelf state beyond atlas");

	a_hit_not_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && hit_q) |-> !cleared_q)
		else $error("hit reported with atlas cleared");

endmodule : glyph_cache_shelf_atlas_core
`default_nettype wire
